// ===== rtl/core/bsr_pkg.sv =====
// Shared types and constants for the bandlimited sinc resampler.
// Used by bandlimited_sinc_resampler; no dependencies.
`timescale 1ns / 1ps

package bsr_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_TABLE = 2'd0,
    OP_PUSH  = 2'd1,
    OP_NEXT  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_RATIO    = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_t;

  // Sequencer states, one-hot
  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_OFF  = 9'b000000010,
    S_OFFW = 9'b000000100,
    S_CHK  = 9'b000001000,
    S_TM1  = 9'b000010000,
    S_TM2  = 9'b000100000,
    S_TACC = 9'b001000000,
    S_FIN1 = 9'b010000000,
    S_FIN2 = 9'b100000000
  } state_t;

  localparam int RatioW  = 24;
  localparam int CapW    = 13;
  localparam int SampW   = 16;
  localparam int CoefW   = 18;
  localparam int ONE_Q16 = 65536;
  localparam int QuotW   = 33;

endpackage

// ===== rtl/core/bandlimited_sinc_resampler.sv =====
// Top level of the bandlimited sinc resampler: sequencer, shared multiplier,
// step divider and the two stores. Depends on bsr_pkg and bsr_ram.
`timescale 1ns / 1ps

// Table-write, push and clear requests complete at the edge that accepts them
// and busy stays low. A next-output request steps each filter tap through the
// check, two multiply and accumulate states on the one shared multiplier, with
// setup and rounding states around them, and it also waits for the bit-serial
// time-step divider that runs alongside. A request that finds the block
// exhausted answers in the next cycle. Each result shows on the out_ ports for
// one cycle with out_valid high and must be taken then, since the receiver
// cannot stall the block. Configuration must be written only while busy is
// low; the block itself does not enforce this.
module bandlimited_sinc_resampler #(
  parameter int MAX_SAMPLES        = 4096,
  parameter int TABLE_LENGTH       = 4096,
  parameter int STEPS_PER_CROSSING = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [11:0]        in_table_index,
  input  logic signed [17:0] in_table_value,
  input  logic signed [15:0] in_sample_in,
  output logic               out_valid,
  output logic signed [15:0] out_sample_out,
  output logic               out_done_res,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int AW    = $clog2(TABLE_LENGTH);
  localparam int SAW   = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int TPW   = CW + 16;
  localparam int FSW   = $clog2(STEPS_PER_CROSSING + 1) + 17;
  localparam int LQB   = $clog2(TABLE_LENGTH + 1) + 16;
  localparam int PW    = ((LQB > FSW) ? LQB : FSW) + 1;
  localparam int ACW   = $clog2(MAX_SAMPLES) + 37;
  localparam int VW    = ACW - 16;
  localparam int MAW   = (VW > FSW + 1) ? VW : FSW + 1;
  localparam int MBW   = 20;
  localparam int PRW   = MAW + MBW;
  localparam logic [TPW-1:0] LIMIT = TPW'(MAX_SAMPLES) << 16;
  localparam logic [PW-1:0]  LQ    = PW'(TABLE_LENGTH) << 16;
  localparam logic signed [PRW-1:0] SMAX = PRW'(32767);
  localparam logic signed [PRW-1:0] SMIN = -PRW'(32768);

  bsr_pkg::state_t state_r, state_nxt;

  logic [bsr_pkg::RatioW-1:0] ratio_r, ratio_nxt;
  logic [bsr_pkg::CapW-1:0]   cap_r, cap_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [TPW-1:0]             tp_r, tp_nxt;
  logic [bsr_pkg::CapW-1:0]   made_r, made_nxt;
  logic                       right_r, right_nxt;
  logic [CW-1:0]              saddr_r, saddr_nxt;
  logic [PW-1:0]              pos_r, pos_nxt;
  logic [FSW-1:0]             fstep_r, fstep_nxt;
  logic [16:0]                scale_r, scale_nxt;
  logic [15:0]                fr_r, fr_nxt;
  logic                       z0_r, z0_nxt, z1_r, z1_nxt;
  logic signed [18:0]         c0_r, c0_nxt;
  logic signed [15:0]         samp_r, samp_nxt;
  logic signed [ACW-1:0]      acc_r, acc_nxt;
  logic signed [PRW-1:0]      prod_r, prod_nxt;
  logic                       ov_r, ov_nxt;
  logic signed [15:0]         os_r, os_nxt;
  logic                       od_r, od_nxt;

  // Divider state
  logic                       dbusy_r, dbusy_nxt;
  logic [5:0]                 dcnt_r, dcnt_nxt;
  logic [24:0]                drem_r, drem_nxt;
  logic [bsr_pkg::QuotW-1:0]  dq_r, dq_nxt;
  logic [bsr_pkg::RatioW-1:0] dden_r, dden_nxt;

  // Store ports
  logic                       cwe, swe;
  logic [AW-1:0]              cwaddr, craddr_a, craddr_b;
  logic [bsr_pkg::CoefW-1:0]  crd_a, crd_b;
  logic [bsr_pkg::SampW-1:0]  srd;

  // Combinational helpers
  bsr_pkg::op_t               op;
  logic                       accept;
  logic [bsr_pkg::RatioW-1:0] ratio_eff;
  logic [15:0]                frac;
  logic [CW-1:0]              idx;
  logic [PW-16-1:0]           kfull;
  logic signed [18:0]         c0_w, c1_w, diff_w, weight_w;
  logic signed [VW-1:0]       vround;
  logic signed [PRW-1:0]      wround;
  logic signed [MAW-1:0]      mul_a;
  logic signed [MBW-1:0]      mul_b;
  logic signed [PRW-1:0]      mul_p;
  logic [24:0]                drem_sh;
  logic                       dge;
  logic [33:0]                tsum;
  logic                       tap_ok;

  assign op        = bsr_pkg::op_t'(in_operation);
  assign accept    = start && !busy;
  assign busy      = (state_r != bsr_pkg::S_IDLE);
  assign ratio_eff = (ratio_r == '0) ? bsr_pkg::RatioW'(1) : ratio_r;
  assign frac      = tp_r[15:0];
  assign idx       = CW'(tp_r >> 16);
  assign kfull     = pos_r[PW-1:16];

  assign out_valid      = ov_r;
  assign out_sample_out = os_r;
  assign out_done_res   = od_r;

  // Coefficient pair with entries past the table end read as zero.
  assign c0_w     = z0_r ? '0 : 19'(signed'(crd_a));
  assign c1_w     = z1_r ? '0 : 19'(signed'(crd_b));
  assign diff_w   = c1_w - c0_w;
  assign weight_w = c0_r + 19'(prod_r >>> 16);
  assign vround   = VW'((acc_r + ACW'(32768)) >>> 16);
  assign wround   = (prod_r + PRW'(32768)) >>> 16;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      bsr_pkg::S_OFF: begin
        mul_a = signed'(MAW'(fstep_r));
        mul_b = signed'(MBW'(right_r ? 17'(bsr_pkg::ONE_Q16 - int'(frac)) : 17'(frac)));
      end
      bsr_pkg::S_TM1: begin
        mul_a = MAW'(diff_w);
        mul_b = signed'(MBW'(fr_r));
      end
      bsr_pkg::S_TM2: begin
        mul_a = MAW'(samp_r);
        mul_b = MBW'(weight_w);
      end
      bsr_pkg::S_FIN1: begin
        mul_a = MAW'(vround);
        mul_b = signed'(MBW'(scale_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PRW'(mul_a) * PRW'(mul_b);

  // Time-step divider step: one quotient bit of 2^32 / ratio per cycle.
  assign drem_sh = {drem_r[23:0], (dcnt_r == '0)};
  assign dge     = (drem_sh >= {1'b0, dden_r});
  assign tsum    = 34'(tp_r) + 34'(dq_r);

  // Tap condition for the current wing.
  assign tap_ok = right_r ? ((pos_r + PW'(fstep_r) <= LQ) && (saddr_r < cnt_r))
                          : (pos_r <= LQ);

  // Store addressing.
  assign cwe      = accept && (op == bsr_pkg::OP_TABLE) &&
                    (32'(in_table_index) < TABLE_LENGTH);
  assign cwaddr   = AW'(in_table_index);
  assign craddr_a = AW'(kfull);
  assign craddr_b = AW'(kfull + 1'b1);
  assign swe      = accept && (op == bsr_pkg::OP_PUSH) && (32'(cnt_r) < MAX_SAMPLES);

  bsr_ram #(.WIDTH(bsr_pkg::CoefW), .DEPTH(TABLE_LENGTH)) u_coef_ram (
    .clk     (clk),
    .we      (cwe),
    .waddr   (cwaddr),
    .wdata   (in_table_value),
    .raddr_a (craddr_a),
    .rdata_a (crd_a),
    .raddr_b (craddr_b),
    .rdata_b (crd_b)
  );

  bsr_ram #(.WIDTH(bsr_pkg::SampW), .DEPTH(MAX_SAMPLES)) u_samp_ram (
    .clk     (clk),
    .we      (swe),
    .waddr   (SAW'(cnt_r)),
    .wdata   (in_sample_in),
    .raddr_a (SAW'(saddr_r)),
    .rdata_a (srd),
    .raddr_b ('0),
    .rdata_b ()
  );

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt = state_r;
    ratio_nxt = ratio_r;
    cap_nxt   = cap_r;
    cnt_nxt   = cnt_r;
    tp_nxt    = tp_r;
    made_nxt  = made_r;
    right_nxt = right_r;
    saddr_nxt = saddr_r;
    pos_nxt   = pos_r;
    fstep_nxt = fstep_r;
    scale_nxt = scale_r;
    fr_nxt    = fr_r;
    z0_nxt    = z0_r;
    z1_nxt    = z1_r;
    c0_nxt    = c0_r;
    samp_nxt  = samp_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    ov_nxt    = 1'b0;
    os_nxt    = os_r;
    od_nxt    = od_r;
    dbusy_nxt = dbusy_r;
    dcnt_nxt  = dcnt_r;
    drem_nxt  = drem_r;
    dq_nxt    = dq_r;
    dden_nxt  = dden_r;

    // Configuration writes.
    if (cfg_we) begin
      case (bsr_pkg::cfg_idx_t'(cfg_index))
        bsr_pkg::CFG_RATIO:    ratio_nxt = cfg_data;
        bsr_pkg::CFG_CAPACITY: cap_nxt   = bsr_pkg::CapW'(cfg_data);
        default:               ratio_nxt = ratio_r;
      endcase
    end

    // Divider runs on its own once started.
    if (dbusy_r) begin
      drem_nxt = dge ? (drem_sh - {1'b0, dden_r}) : drem_sh;
      dq_nxt   = {dq_r[bsr_pkg::QuotW-2:0], dge};
      dcnt_nxt = dcnt_r + 1'b1;
      if (dcnt_r == 6'(bsr_pkg::QuotW - 1)) begin
        dbusy_nxt = 1'b0;
      end
    end

    unique case (state_r)
      bsr_pkg::S_IDLE: begin
        if (accept) begin
          unique case (op)
            bsr_pkg::OP_TABLE: begin
              state_nxt = bsr_pkg::S_IDLE;
            end
            bsr_pkg::OP_PUSH: begin
              if (swe) begin
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            bsr_pkg::OP_CLEAR: begin
              cnt_nxt  = '0;
              tp_nxt   = '0;
              made_nxt = '0;
            end
            bsr_pkg::OP_NEXT: begin
              if ((tp_r >= {cnt_r, 16'h0000}) || (made_r >= cap_r)) begin
                // Nothing left to make: answer at once.
                ov_nxt = 1'b1;
                os_nxt = '0;
                od_nxt = 1'b1;
              end else begin
                scale_nxt = (ratio_eff >= bsr_pkg::RatioW'(bsr_pkg::ONE_Q16)) ?
                            17'(bsr_pkg::ONE_Q16) : 17'(ratio_eff);
                fstep_nxt = FSW'(STEPS_PER_CROSSING) * FSW'(scale_nxt);
                right_nxt = 1'b0;
                acc_nxt   = '0;
                dbusy_nxt = 1'b1;
                dcnt_nxt  = '0;
                drem_nxt  = '0;
                dq_nxt    = '0;
                dden_nxt  = ratio_eff;
                state_nxt = bsr_pkg::S_OFF;
              end
            end
            default: state_nxt = bsr_pkg::S_IDLE;
          endcase
        end
      end

      // Wing start offset into the table.
      bsr_pkg::S_OFF: begin
        prod_nxt  = mul_p;
        state_nxt = bsr_pkg::S_OFFW;
      end

      bsr_pkg::S_OFFW: begin
        pos_nxt   = PW'(prod_r[PRW-1:16]);
        saddr_nxt = right_r ? (idx + 1'b1) : idx;
        state_nxt = bsr_pkg::S_CHK;
      end

      // Decide on the next tap and issue its store reads.
      bsr_pkg::S_CHK: begin
        fr_nxt = pos_r[15:0];
        z0_nxt = (32'(kfull) >= TABLE_LENGTH);
        z1_nxt = (32'(kfull) + 1 >= TABLE_LENGTH);
        if (tap_ok) begin
          state_nxt = bsr_pkg::S_TM1;
        end else if (right_r) begin
          state_nxt = bsr_pkg::S_FIN1;
        end else begin
          right_nxt = 1'b1;
          state_nxt = bsr_pkg::S_OFF;
        end
      end

      // Interpolation between neighboring table entries.
      bsr_pkg::S_TM1: begin
        c0_nxt    = c0_w;
        samp_nxt  = signed'(srd);
        prod_nxt  = mul_p;
        state_nxt = bsr_pkg::S_TM2;
      end

      // Sample times weight.
      bsr_pkg::S_TM2: begin
        prod_nxt  = mul_p;
        state_nxt = bsr_pkg::S_TACC;
      end

      // Accumulate and step to the next tap.
      bsr_pkg::S_TACC: begin
        acc_nxt = acc_r + ACW'(prod_r);
        pos_nxt = pos_r + PW'(fstep_r);
        if (right_r) begin
          saddr_nxt = saddr_r + 1'b1;
          state_nxt = bsr_pkg::S_CHK;
        end else if (saddr_r == '0) begin
          right_nxt = 1'b1;
          state_nxt = bsr_pkg::S_OFF;
        end else begin
          saddr_nxt = saddr_r - 1'b1;
          state_nxt = bsr_pkg::S_CHK;
        end
      end

      // Round the sum and apply the filter scale.
      bsr_pkg::S_FIN1: begin
        prod_nxt  = mul_p;
        state_nxt = bsr_pkg::S_FIN2;
      end

      // Saturate, advance time once the step is known.
      bsr_pkg::S_FIN2: begin
        if (!dbusy_r) begin
          if (wround > SMAX) begin
            os_nxt = 16'sh7FFF;
          end else if (wround < SMIN) begin
            os_nxt = -16'sh8000;
          end else begin
            os_nxt = 16'(wround);
          end
          od_nxt    = 1'b0;
          ov_nxt    = 1'b1;
          tp_nxt    = (tsum > 34'(LIMIT)) ? LIMIT : TPW'(tsum);
          made_nxt  = made_r + 1'b1;
          state_nxt = bsr_pkg::S_IDLE;
        end
      end

      default: state_nxt = bsr_pkg::S_IDLE;
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsr_pkg::S_IDLE;
      ratio_r <= bsr_pkg::RatioW'(bsr_pkg::ONE_Q16);
      cap_r   <= bsr_pkg::CapW'(4096);
      cnt_r   <= '0;
      tp_r    <= '0;
      made_r  <= '0;
      ov_r    <= 1'b0;
      dbusy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ratio_r <= ratio_nxt;
      cap_r   <= cap_nxt;
      cnt_r   <= cnt_nxt;
      tp_r    <= tp_nxt;
      made_r  <= made_nxt;
      ov_r    <= ov_nxt;
      dbusy_r <= dbusy_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    right_r <= right_nxt;
    saddr_r <= saddr_nxt;
    pos_r   <= pos_nxt;
    fstep_r <= fstep_nxt;
    scale_r <= scale_nxt;
    fr_r    <= fr_nxt;
    z0_r    <= z0_nxt;
    z1_r    <= z1_nxt;
    c0_r    <= c0_nxt;
    samp_r  <= samp_nxt;
    acc_r   <= acc_nxt;
    prod_r  <= prod_nxt;
    os_r    <= os_nxt;
    od_r    <= od_nxt;
    dcnt_r  <= dcnt_nxt;
    drem_r  <= drem_nxt;
    dq_r    <= dq_nxt;
    dden_r  <= dden_nxt;
  end

  // A computed (not done) result only follows the final rounding state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> $past(state_r == bsr_pkg::S_FIN2))
    else $error("computed result without final state");

  // Time position never passes the block limit.
  a_tp_limit: assert property (@(posedge clk) disable iff (!rst_n)
    tp_r <= LIMIT)
    else $error("time position beyond limit");

  // Sample count never passes the store depth.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_SAMPLES)
    else $error("sample count beyond store depth");

  // Tap reads are always issued in the check state.
  a_tap_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bsr_pkg::S_TM1 |-> $past(state_r == bsr_pkg::S_CHK))
    else $error("tap started without read");

endmodule

// ===== rtl/core/bsr_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; used for the sample and coefficient stores.
`timescale 1ns / 1ps

module bsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and two registered reads per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
